@@ rtl/btlpm_pkg.sv @@
// Shared types and constants for the binary trie longest-prefix-match engine.
// No dependencies; imported by every module of the block.
package btlpm_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 6;
    localparam int MAX_LEN        = 32;

    typedef enum logic [1:0] {
        ST_INSERT_DONE = 2'd0,
        ST_HIT         = 2'd1,
        ST_MISS        = 2'd2,
        ST_POOL_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CREATE,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } command_t;

    typedef struct packed {
        logic start;
        logic walk;
        logic create;
        logic commit;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_stop;
        logic pool_full;
        logic at_target;
        logic last_create;
        logic is_lookup;
    } dp_stat_t;

endpackage

@@ rtl/btlpm_ctrl.sv @@
// Sequencer for the trie engine: walk, node creation, commit, result hand-off.
// Depends on btlpm_pkg; drives btlpm_dp through dp_cmd_t.
module btlpm_ctrl
    import btlpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.walk_stop)
                begin
                    if (stat.is_lookup || stat.pool_full)
                    begin
                        state_next = S_DONE;
                    end
                    else if (stat.at_target)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_CREATE;
                    end
                end
            end
            S_CREATE:
            begin
                if (stat.last_create)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.start    = (state_reg == S_IDLE) && in_valid;
        cmd.walk     = (state_reg == S_WALK);
        cmd.create   = (state_reg == S_CREATE);
        cmd.commit   = (state_reg == S_COMMIT);
        cmd.load_out = (state_reg == S_DONE) && slot_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/btlpm_dp.sv @@
// Datapath of the trie engine: node memory, walk registers, free pointer, result.
// Depends on btlpm_pkg; sequenced by btlpm_ctrl.
module btlpm_dp
    import btlpm_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic              command,
    input  logic [ADDR_W-1:0] net_address,
    input  logic [LEN_W-1:0]  prefix_len,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] match_prefix,
    output logic [LEN_W-1:0]  match_len
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int FREE_W = $clog2(NODE_COUNT + 1);

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [IDX_W-1:0]  child1;
        logic [IDX_W-1:0]  child0;
    } entry_t;

    entry_t mem [NODE_COUNT];

    entry_t             rd_data_reg;
    logic [IDX_W-1:0]   rd_node_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    logic               lookup_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   depth_reg;
    logic [IDX_W-1:0]   node_reg;
    entry_t             cur_reg;
    logic               found_reg;
    logic [ADDR_W-1:0]  best_prefix_reg;
    logic [LEN_W-1:0]   best_len_reg;
    status_t            pend_reg;
    status_t            status_reg;
    logic [ADDR_W-1:0]  match_prefix_reg;
    logic [LEN_W-1:0]   match_len_reg;

    logic [FREE_W-1:0]  free_reg;
    logic [FREE_W-1:0]  free_next;
    logic               root_init_reg;
    logic               root_init_next;

    entry_t             entry;
    logic               bit_sel;
    logic [IDX_W-1:0]   child;
    logic               at_target;
    logic               walk_stop;
    logic [LEN_W-1:0]   missing;
    logic [FREE_W-1:0]  free_left;
    logic               pool_full;
    logic [LEN_W-1:0]   depth_inc;
    logic [IDX_W-1:0]   new_idx;

    // The root is never written at reset; it reads as empty until first written.
    assign entry     = (rd_node_reg == '0 && !root_init_reg) ? '0 : rd_data_reg;
    assign bit_sel   = addr_reg[~depth_reg[4:0]];
    assign child     = bit_sel ? entry.child1 : entry.child0;
    assign at_target = (depth_reg == len_reg);
    assign depth_inc = depth_reg + LEN_W'(1);
    assign missing   = at_target ? '0 : (len_reg - depth_reg);
    assign free_left = FREE_W'(NODE_COUNT) - free_reg;
    assign pool_full = !lookup_reg && (FREE_W'(missing) > free_left);
    assign new_idx   = free_reg[IDX_W-1:0];

    always_comb
    begin
        if (lookup_reg)
        begin
            walk_stop = depth_reg[5] || (child == '0);
        end
        else
        begin
            walk_stop = at_target || (child == '0);
        end
    end

    always_comb
    begin
        stat             = '0;
        stat.walk_stop   = walk_stop;
        stat.pool_full   = pool_full;
        stat.at_target   = at_target;
        stat.last_create = (depth_inc == len_reg);
        stat.is_lookup   = lookup_reg;
    end

    always_comb
    begin
        rd_addr = '0;
        if (cmd.walk && !walk_stop)
        begin
            rd_addr = child;
        end
    end

    always_comb
    begin
        wr_en   = cmd.create || cmd.commit;
        wr_addr = node_reg;
        wr_data = cur_reg;
        if (cmd.create)
        begin
            if (bit_sel)
            begin
                wr_data.child1 = new_idx;
            end
            else
            begin
                wr_data.child0 = new_idx;
            end
        end
        else
        begin
            wr_data.valid  = 1'b1;
            wr_data.prefix = addr_reg;
            wr_data.len    = len_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_node_reg <= rd_addr;
    end

    always_comb
    begin
        free_next      = free_reg;
        root_init_next = root_init_reg;
        if (cmd.create)
        begin
            free_next = free_reg + FREE_W'(1);
        end
        if (wr_en && node_reg == '0)
        begin
            root_init_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= FREE_W'(1);
            root_init_reg <= 1'b0;
        end
        else
        begin
            free_reg      <= free_next;
            root_init_reg <= root_init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lookup_reg      <= (command == CMD_LOOKUP);
            addr_reg        <= net_address;
            len_reg         <= (prefix_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : prefix_len;
            depth_reg       <= '0;
            found_reg       <= 1'b0;
            best_prefix_reg <= '0;
            best_len_reg    <= '0;
        end
        else if (cmd.walk)
        begin
            if (lookup_reg && entry.valid)
            begin
                found_reg       <= 1'b1;
                best_prefix_reg <= entry.prefix;
                best_len_reg    <= entry.len;
            end
            if (!walk_stop)
            begin
                depth_reg <= depth_inc;
            end
            else
            begin
                node_reg <= rd_node_reg;
                cur_reg  <= entry;
                if (lookup_reg)
                begin
                    pend_reg <= (found_reg || entry.valid) ? ST_HIT : ST_MISS;
                end
                else if (pool_full)
                begin
                    pend_reg <= ST_POOL_FULL;
                end
                else
                begin
                    pend_reg <= ST_INSERT_DONE;
                end
            end
        end
        else if (cmd.create)
        begin
            node_reg  <= new_idx;
            cur_reg   <= '0;
            depth_reg <= depth_inc;
        end

        if (cmd.load_out)
        begin
            status_reg       <= pend_reg;
            match_prefix_reg <= (pend_reg == ST_HIT) ? best_prefix_reg : '0;
            match_len_reg    <= (pend_reg == ST_HIT) ? best_len_reg : '0;
        end
    end

    assign status       = status_reg;
    assign match_prefix = match_prefix_reg;
    assign match_len    = match_len_reg;

endmodule

@@ rtl/binary_trie_longest_prefix_match.sv @@
// Top level of the IPv4 longest-prefix-match engine over a one-bit binary trie.
// Depends on btlpm_pkg, btlpm_ctrl and btlpm_dp.
//
// Input channel (in_valid/in_stall): command, net_address, prefix_len.
// Command insert stores net_address at trie depth prefix_len (above 32 taken
// as 32); command lookup returns the deepest stored prefix on the address path.
// Output channel (out_valid/out_stall): status, match_prefix, match_len, one
// transfer per input transfer, in order.
// One item at a time. The node memory gives one read per trie level; an insert
// walks the existing levels, then makes one write per new node plus the final
// write. The result sits in an output register, so the next item is taken
// while it waits; if out_stall is held, the following result is kept back and
// the input stays stalled until the output register frees.
// Reset empties the trie (the root reads as empty until written, and the
// free pointer returns to node 1); no clearing pass is needed and items are
// taken from the first cycle after reset.
module binary_trie_longest_prefix_match
    import btlpm_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [ADDR_W-1:0] net_address,
    input  logic [LEN_W-1:0]  prefix_len,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] match_prefix,
    output logic [LEN_W-1:0]  match_len
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    btlpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    btlpm_dp #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .command      (command),
        .net_address  (net_address),
        .prefix_len   (prefix_len),
        .status       (status),
        .match_prefix (match_prefix),
        .match_len    (match_len)
    );

endmodule

@@ rtl/btlpm_checker.sv @@
// Port-level checks for the trie engine, bound to the top level.
// Depends on btlpm_pkg and binary_trie_longest_prefix_match.
module btlpm_checker
    import btlpm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        status,
    input logic [ADDR_W-1:0] match_prefix,
    input logic [LEN_W-1:0]  match_len
);

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(match_prefix) && $stable(match_len))
        else $error("stalled result changed");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_HIT |-> match_prefix == '0 && match_len == '0)
        else $error("non-hit result carries match data");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> match_len <= LEN_W'(MAX_LEN))
        else $error("match length out of range");

endmodule

bind binary_trie_longest_prefix_match btlpm_checker u_btlpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .match_prefix (match_prefix),
    .match_len    (match_len)
);

@@ test/testbench.sv @@
// Self-checking testbench for the binary trie longest-prefix-match engine.
// Needs btlpm_pkg and binary_trie_longest_prefix_match; runs directed and random
// insert/lookup transfers against its own trie predictor with random idling.
module testbench;
    import btlpm_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        command_t          cmd;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  plen;
        bit                drain_first;
    } route_op_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
    } lpm_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              command = CMD_INSERT;
    logic [ADDR_W-1:0] net_address = '0;
    logic [LEN_W-1:0]  prefix_len = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic [ADDR_W-1:0] match_prefix;
    logic [LEN_W-1:0]  match_len;

    // predictor copy of the trie
    bit                trie_valid [NODE_COUNT_DEF];
    logic [ADDR_W-1:0] trie_prefix [NODE_COUNT_DEF];
    logic [LEN_W-1:0]  trie_len [NODE_COUNT_DEF];
    int                trie_child [NODE_COUNT_DEF][2];
    int                trie_next_free;

    route_op_t         route_ops [$];
    lpm_result_t       pending_answers [$];
    logic [ADDR_W-1:0] known_prefixes [$];
    int                known_lens [$];

    logic in_fire = 1'b0;
    int   gap_left = 0;
    int   stall_run = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   cycle_count = 0;
    int   answers_seen = 0;
    int   mismatch_count = 0;
    int   status_tally [4];
    logic quiet;

    assign quiet = (cycle_count[9:8] == 2'b11);

    binary_trie_longest_prefix_match i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .net_address  (net_address),
        .prefix_len   (prefix_len),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .match_prefix (match_prefix),
        .match_len    (match_len)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic lpm_result_t trie_apply(command_t cmd, logic [ADDR_W-1:0] addr,
                                               logic [LEN_W-1:0] plen);
        lpm_result_t r;
        int depth_lim;
        int node;
        int nxt;
        int missing;
        int d;
        bit found;
        r.status = ST_MISS;
        r.prefix = '0;
        r.len    = '0;
        node     = 0;
        if (cmd == CMD_INSERT)
        begin
            depth_lim = (plen > MAX_LEN) ? MAX_LEN : int'(plen);
            missing   = 0;
            for (d = 0; d < depth_lim; d++)
            begin
                nxt = trie_child[node][addr[ADDR_W-1-d]];
                if (nxt == 0)
                begin
                    missing = depth_lim - d;
                    break;
                end
                node = nxt;
            end
            if (missing > NODE_COUNT_DEF - trie_next_free)
                r.status = ST_POOL_FULL;
            else
            begin
                node = 0;
                for (d = 0; d < depth_lim; d++)
                begin
                    nxt = trie_child[node][addr[ADDR_W-1-d]];
                    if (nxt == 0)
                    begin
                        nxt = trie_next_free;
                        trie_next_free++;
                        trie_valid[nxt]    = 1'b0;
                        trie_child[nxt][0] = 0;
                        trie_child[nxt][1] = 0;
                        trie_child[node][addr[ADDR_W-1-d]] = nxt;
                    end
                    node = nxt;
                end
                trie_valid[node]  = 1'b1;
                trie_prefix[node] = addr;
                trie_len[node]    = LEN_W'(depth_lim);
                r.status = ST_INSERT_DONE;
            end
        end
        else
        begin
            found = 1'b0;
            for (d = 0; d <= MAX_LEN; d++)
            begin
                if (trie_valid[node])
                begin
                    found    = 1'b1;
                    r.prefix = trie_prefix[node];
                    r.len    = trie_len[node];
                end
                if (d == MAX_LEN)
                    break;
                nxt = trie_child[node][addr[ADDR_W-1-d]];
                if (nxt == 0)
                    break;
                node = nxt;
            end
            if (found)
                r.status = ST_HIT;
        end
        return r;
    endfunction

    function automatic void add_op(command_t cmd, logic [ADDR_W-1:0] addr, int plen,
                                   bit drain_first);
        route_op_t op;
        op.cmd         = cmd;
        op.addr        = addr;
        op.plen        = LEN_W'(plen);
        op.drain_first = drain_first;
        route_ops.push_back(op);
        if (cmd == CMD_INSERT)
        begin
            known_prefixes.push_back(addr);
            known_lens.push_back((plen > MAX_LEN) ? MAX_LEN : plen);
        end
    endfunction

    function automatic int draw_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input side: prediction at each transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            pending_answers.push_back(trie_apply(command_t'(command), net_address, prefix_len));
            in_fire <= 1'b1;
        end
        else
            in_fire <= 1'b0;
    end

    always @(negedge clk)
    begin : driver
        route_op_t op;
        if (rst_n && !(in_valid && !in_fire))
        begin
            if (in_fire)
                gap_left = draw_gap();
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (route_ops.size() != 0 &&
                     (!route_ops[0].drain_first || pending_answers.size() == 0))
            begin
                op = route_ops.pop_front();
                in_valid    <= 1'b1;
                command     <= op.cmd;
                net_address <= op.addr;
                prefix_len  <= op.plen;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        logic stall_next;
        stall_next = 1'b0;
        if (!hold_done && answers_seen >= 300)
        begin
            hold_left = 240;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            stall_next = 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            stall_next = 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < 25)
        begin
            stall_run  = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 2);
            stall_next = 1'b1;
        end
        out_stall <= stall_next;
    end

    always @(posedge clk)
    begin : result_monitor
        lpm_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d prefix %h len %0d",
                             status, match_prefix, match_len);
            end
            else
            begin
                e = pending_answers.pop_front();
                status_tally[e.status]++;
                if (status !== e.status || match_prefix !== e.prefix || match_len !== e.len)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at result %0d: expected status %0d prefix %h len %0d, got status %0d prefix %h len %0d",
                                 answers_seen, e.status, e.prefix, e.len,
                                 status, match_prefix, match_len);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_answers.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        int k;
        int n;
        int roll;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] m;
        for (i = 0; i < NODE_COUNT_DEF; i++)
        begin
            trie_valid[i]    = 1'b0;
            trie_child[i][0] = 0;
            trie_child[i][1] = 0;
        end
        trie_next_free = 1;

        // empty trie, default route with host bits, both /32 extremes
        add_op(CMD_LOOKUP, 32'h0000_0000, 0, 1'b0);
        add_op(CMD_LOOKUP, 32'hFFFF_FFFF, 63, 1'b0);
        add_op(CMD_INSERT, 32'h1234_5678, 0, 1'b0);
        add_op(CMD_LOOKUP, 32'hDEAD_BEEF, 0, 1'b0);
        add_op(CMD_INSERT, 32'hFFFF_FFFF, 32, 1'b0);
        add_op(CMD_LOOKUP, 32'hFFFF_FFFF, 0, 1'b0);
        add_op(CMD_LOOKUP, 32'hFFFF_FFFE, 0, 1'b0);
        add_op(CMD_INSERT, 32'h0000_0000, 32, 1'b0);
        add_op(CMD_LOOKUP, 32'h0000_0000, 32, 1'b0);
        // nested prefixes and overwrite of an existing entry
        add_op(CMD_INSERT, 32'hC0A8_0000, 16, 1'b0);
        add_op(CMD_INSERT, 32'hC0A8_0101, 24, 1'b0);
        add_op(CMD_LOOKUP, 32'hC0A8_01FF, 0, 1'b0);
        add_op(CMD_LOOKUP, 32'hC0A8_02FF, 0, 1'b0);
        add_op(CMD_INSERT, 32'hC0A8_0177, 24, 1'b0);
        add_op(CMD_LOOKUP, 32'hC0A8_0105, 45, 1'b0);
        // over-long lengths saturate to 32
        add_op(CMD_INSERT, 32'h0A00_0000, 63, 1'b0);
        add_op(CMD_INSERT, 32'h0A00_0000, 33, 1'b0);
        add_op(CMD_LOOKUP, 32'h0A00_0000, 0, 1'b0);
        add_op(CMD_LOOKUP, 32'h0A00_0001, 0, 1'b0);
        add_op(CMD_INSERT, 32'h8000_0000, 1, 1'b0);
        add_op(CMD_LOOKUP, 32'h8000_0001, 0, 1'b0);
        add_op(CMD_INSERT, 32'h0000_0000, 0, 1'b0);
        add_op(CMD_LOOKUP, 32'h7777_7777, 17, 1'b0);

        // random part; the pool fills part way through
        for (i = 0; i < 680; i++)
        begin
            if ($urandom_range(0, 99) < 50)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    n = $urandom_range(24, 32);
                else if (roll < 85)
                    n = $urandom_range(0, 23);
                else
                    n = $urandom_range(33, 63);
                if ($urandom_range(0, 99) < 40)
                begin
                    k = $urandom_range(0, known_prefixes.size() - 1);
                    a = known_prefixes[k] ^ ($urandom >> $urandom_range(8, 31));
                end
                else
                    a = $urandom;
                add_op(CMD_INSERT, a, n, i == 0 || i == 350);
            end
            else
            begin
                if ($urandom_range(0, 99) < 65)
                begin
                    k = $urandom_range(0, known_prefixes.size() - 1);
                    n = known_lens[k];
                    m = (n == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - n));
                    a = (known_prefixes[k] & m) | ($urandom & ~m);
                end
                else
                    a = $urandom;
                add_op(CMD_LOOKUP, a, $urandom_range(0, 63), i == 0 || i == 350);
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (route_ops.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Checked %0d results: %0d inserts stored, %0d refused for a full pool,",
                 answers_seen, status_tally[ST_INSERT_DONE], status_tally[ST_POOL_FULL]);
        $display("%0d lookup hits, %0d lookup misses; %0d trie nodes in use, %0d mismatches.",
                 status_tally[ST_HIT], status_tally[ST_MISS], trie_next_free, mismatch_count);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
